// ===== sv/olt_pkg.sv =====
// Package for the ordered list table: operation and status codes, sequencer states
// and default sizes. It depends on nothing else.
`default_nettype none

package olt_pkg;

  // Default number of list entries.
  localparam int unsigned DEPTH_DEFAULT = 64;

  // Widths of the transfer fields.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Status codes carried by a response.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_SCAN   = 2'd2,
    S_FINISH = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== sv/olt_req_if.sv =====
// Request channel of the ordered list table: valid/ready and the request fields.
// Depends on olt_pkg.
`default_nettype none

interface olt_req_if;
  logic                        valid;
  logic                        ready;
  olt_pkg::op_t                operation;
  logic [olt_pkg::VALUE_W-1:0] value;
  logic [olt_pkg::POS_W-1:0]   position;

  modport source (output valid, operation, value, position, input ready);
  modport sink (input valid, operation, value, position, output ready);
endinterface

`default_nettype wire

// ===== sv/olt_rsp_if.sv =====
// Response channel of the ordered list table: valid/ready and the result fields.
// Depends on olt_pkg.
`default_nettype none

interface olt_rsp_if;
  logic                        valid;
  logic                        ready;
  olt_pkg::status_t            status;
  logic [olt_pkg::VALUE_W-1:0] read_data;
  logic [olt_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, read_data, entry_count, input ready);
  modport sink (input valid, status, read_data, entry_count, output ready);
endinterface

`default_nettype wire

// ===== sv/ordered_list_table_core.sv =====
// Top level of the ordered list table: entry memory, count and the scan sequencer.
// Depends on olt_pkg, olt_req_if and olt_rsp_if.
//
//   channel | direction | payload                              | handshake
//   req     | in        | operation, value, position           | valid/ready
//   rsp     | out       | status, read_data, entry_count       | valid/ready
//
// Append, clear and a failed read go from idle to the finish state; a good read
// goes through the read state first. Remove scans, paced by the single read port
// of the memory, which the compare unit walks one entry per cycle while compacting.
// One request is in flight at a time; req.ready is high only in the idle state.
// A stalled response holds in the output register and the sequencer waits for it.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
`default_nettype none

module ordered_list_table_core #(
  parameter int unsigned DEPTH = olt_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  olt_req_if.sink   req,
  olt_rsp_if.source rsp
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;
  localparam int unsigned VW    = olt_pkg::VALUE_W;

  // Sequencer and list state.
  olt_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [VW-1:0]    value_q, value_q_next;
  logic [CW-1:0]    kept, kept_next;
  logic [CW-1:0]    rd_idx, rd_idx_next;
  logic [CW-1:0]    left, left_next;
  olt_pkg::status_t pend_status, pend_status_next;
  logic [VW-1:0]    pend_data, pend_data_next;

  // Output register.
  logic                        rsp_valid, rsp_valid_next;
  olt_pkg::status_t            rsp_status, rsp_status_next;
  logic [VW-1:0]               rsp_data, rsp_data_next;
  logic [olt_pkg::COUNT_W-1:0] rsp_count, rsp_count_next;

  // Entry memory ports.
  logic [VW-1:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [VW-1:0] mem_wd, rd_q;

  logic req_xfer, pos_ok, keep_hit, rsp_free;

  assign req_xfer = req.valid && req.ready;
  assign pos_ok   = CMP_W'(req.position) < CMP_W'(count);
  assign keep_hit = rd_q != value_q;
  assign rsp_free = !rsp_valid || rsp.ready;

  assign req.ready       = (state == olt_pkg::S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.read_data   = rsp_data;
  assign rsp.entry_count = rsp_count;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      olt_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.operation)
            olt_pkg::OP_READ:   state_next = pos_ok ? olt_pkg::S_READ : olt_pkg::S_FINISH;
            olt_pkg::OP_REMOVE: state_next = (count != '0) ? olt_pkg::S_SCAN
                                                           : olt_pkg::S_FINISH;
            default:            state_next = olt_pkg::S_FINISH;
          endcase
        end
      end
      olt_pkg::S_READ: state_next = olt_pkg::S_FINISH;
      olt_pkg::S_SCAN: begin
        if (left == CW'(1)) begin
          state_next = olt_pkg::S_FINISH;
        end
      end
      olt_pkg::S_FINISH: begin
        if (rsp_free) begin
          state_next = olt_pkg::S_IDLE;
        end
      end
      default: state_next = olt_pkg::S_IDLE;
    endcase
  end

  // Datapath control: memory ports, counters and the output register.
  always_comb begin
    count_next       = count;
    value_q_next     = value_q;
    kept_next        = kept;
    rd_idx_next      = rd_idx;
    left_next        = left;
    pend_status_next = pend_status;
    pend_data_next   = pend_data;
    mem_we           = 1'b0;
    mem_wa           = '0;
    mem_wd           = rd_q;
    mem_re           = 1'b0;
    mem_ra           = '0;
    rsp_valid_next   = rsp_valid && !rsp.ready;
    rsp_status_next  = rsp_status;
    rsp_data_next    = rsp_data;
    rsp_count_next   = rsp_count;

    case (state)
      olt_pkg::S_IDLE: begin
        if (req_xfer) begin
          pend_status_next = olt_pkg::ST_OK;
          pend_data_next   = '0;
          case (req.operation)
            olt_pkg::OP_APPEND: begin
              if (count == CW'(DEPTH)) begin
                pend_status_next = olt_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = AW'(count);
                mem_wd     = req.value;
                count_next = count + CW'(1);
              end
            end
            olt_pkg::OP_REMOVE: begin
              // Start the scan: fetch entry 0, compact from slot 0.
              value_q_next = req.value;
              mem_re       = 1'b1;
              mem_ra       = '0;
              rd_idx_next  = CW'(1);
              left_next    = count;
              kept_next    = '0;
            end
            olt_pkg::OP_READ: begin
              if (pos_ok) begin
                mem_re = 1'b1;
                mem_ra = AW'(req.position);
              end else begin
                pend_status_next = olt_pkg::ST_RANGE;
              end
            end
            default: count_next = '0;
          endcase
        end
      end
      olt_pkg::S_READ: pend_data_next = rd_q;
      olt_pkg::S_SCAN: begin
        // Survivors are written back at the compacted slot, which never passes
        // the slot being fetched.
        if (keep_hit) begin
          mem_we    = 1'b1;
          mem_wa    = AW'(kept);
          mem_wd    = rd_q;
          kept_next = kept + CW'(1);
        end
        if (rd_idx < count) begin
          mem_re = 1'b1;
          mem_ra = AW'(rd_idx);
        end
        rd_idx_next = rd_idx + CW'(1);
        left_next   = left - CW'(1);
        if (left == CW'(1)) begin
          count_next = kept + CW'(keep_hit);
        end
      end
      olt_pkg::S_FINISH: begin
        if (rsp_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = pend_status;
          rsp_data_next   = pend_data;
          rsp_count_next  = olt_pkg::COUNT_W'(count);
        end
      end
      default: ;
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olt_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_q     <= value_q_next;
    kept        <= kept_next;
    rd_idx      <= rd_idx_next;
    left        <= left_next;
    pend_status <= pend_status_next;
    pend_data   <= pend_data_next;
    rsp_status  <= rsp_status_next;
    rsp_data    <= rsp_data_next;
    rsp_count   <= rsp_count_next;
  end

endmodule

`default_nettype wire

// ===== sv/olt_checker.sv =====
// Port-level checks of the ordered list table and the bind that attaches them.
// Depends on olt_pkg and ordered_list_table_core.
`default_nettype none

module olt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [1:0]                  rsp_status,
  input wire logic [olt_pkg::VALUE_W-1:0] rsp_read_data,
  input wire logic [olt_pkg::COUNT_W-1:0] rsp_entry_count
);

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_data) && $stable(rsp_entry_count))
    else $error("response changed while stalled");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // Failed operations return no data.
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == olt_pkg::ST_FULL || rsp_status == olt_pkg::ST_RANGE)
      |-> rsp_read_data == '0)
    else $error("failed operation returned data");

  // The undefined status code never appears.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("unknown status code");

endmodule

bind ordered_list_table_core olt_checker u_olt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_data   (rsp.read_data),
  .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

// ===== tb/olt_list_checker.sv =====
// Scoreboard for the ordered list table: watches the request and response channels,
// keeps a shadow copy of the list, and compares every response with its prediction.
// Depends on olt_pkg, olt_req_if and olt_rsp_if.
`default_nettype none

module olt_list_checker #(
  parameter int unsigned DEPTH = olt_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  olt_req_if        req,
  olt_rsp_if        rsp,
  output int        fail_count,
  output int        outstanding,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import olt_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   read_data;
    logic [COUNT_W-1:0]   entry_count;
  } list_result_t;

  // Shadow copy of the stored values and their count.
  logic [VALUE_W-1:0] shadow_entries [DEPTH];
  int unsigned        shadow_len;

  // Responses predicted for accepted requests, oldest first.
  list_result_t awaited_results [$];

  // Applies one request to the shadow list and returns the response it should produce.
  function automatic list_result_t apply_list_op(op_t op, logic [VALUE_W-1:0] val,
                                                 logic [POS_W-1:0] pos);
    list_result_t res;
    int unsigned  kept;
    res.status    = ST_OK;
    res.read_data = '0;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        // Survivors slide down over the removed entries and keep their order.
        kept = 0;
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_entries[i] != val) begin
            shadow_entries[kept] = shadow_entries[i];
            kept++;
          end
        end
        shadow_len = kept;
      end
      OP_READ: begin
        if (pos < shadow_len && pos < DEPTH) begin
          res.read_data = shadow_entries[pos];
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    res.entry_count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  // Response transfers are matched before the request of the same edge is predicted.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    int           errs;
    errs = 0;
    if (rst) begin
      shadow_len = 0;
      awaited_results.delete();
      fail_count  <= 0;
      checked     <= 0;
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.read_data, rsp.entry_count};
        if (awaited_results.size() == 0) begin
          $display("%0t: response with nothing outstanding: status %0d data %h count %0d",
                   $time, got.status, got.read_data, got.entry_count);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h actual %h",
                     $time, want.read_data, got.read_data);
            errs++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            errs++;
          end
        end
        checked <= checked + 1;
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(apply_list_op(req.operation, req.value, req.position));
      end
      fail_count  <= fail_count + errs;
      outstanding <= awaited_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the ordered list table testbench: clock, reset, request stimulus and response
// pacing, with the verdict taken from olt_list_checker. Depends on olt_pkg, the channel
// interfaces, ordered_list_table_core and olt_list_checker.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olt_pkg::*;

  localparam int unsigned DEPTH           = DEPTH_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned PHASES          = 9;

  // Operation mixes of the random phases.
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_LOOKUP, MIX_EVEN} op_mix_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   checked;
  bit   quiet;
  int   sent_by_op [4];
  logic [VALUE_W-1:0] value_pool [8];

  olt_req_if req_ch ();
  olt_rsp_if rsp_ch ();

  ordered_list_table_core #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  olt_list_checker #(.DEPTH(DEPTH)) list_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Timeout with %0d responses still outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // Response side: ready drops in random bursts, and stays high once the run goes quiet.
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      n = $urandom_range(1, 20);
      rsp_ch.ready <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  // Offers one request, after an optional idle burst, and returns at its transfer.
  task automatic send_item(op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    req_ch.position  <= pos;
    sent_by_op[int'(op)]++;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Values come mostly from a small pool so that removes find matches and duplicates.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return value_pool[$urandom_range(0, 7)];
    end else if (r < 90) begin
      return $urandom;
    end else begin
      return $urandom_range(0, 1) ? '1 : '0;
    end
  endfunction

  // Positions lean toward the low end, where entries usually exist.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 1) begin
      return POS_W'($urandom_range(0, 15));
    end
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic op_t pick_op(op_mix_t mix);
    int unsigned r;
    int unsigned w_app;
    int unsigned w_rem;
    int unsigned w_rd;
    case (mix)
      MIX_GROW:   begin w_app = 80; w_rem = 4;  w_rd = 16; end
      MIX_SHRINK: begin w_app = 25; w_rem = 45; w_rd = 25; end
      MIX_LOOKUP: begin w_app = 30; w_rem = 10; w_rd = 58; end
      default:    begin w_app = 40; w_rem = 20; w_rd = 35; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_app) return OP_APPEND;
    if (r < w_app + w_rem) return OP_REMOVE;
    if (r < w_app + w_rem + w_rd) return OP_READ;
    return OP_CLEAR;
  endfunction

  // One random phase with a fresh value pool that always holds both extremes.
  task automatic run_phase(op_mix_t mix);
    value_pool[0] = '0;
    value_pool[7] = '1;
    for (int i = 1; i < 7; i++) begin
      value_pool[i] = $urandom;
    end
    repeat (ITEMS_PER_PHASE) begin
      send_item(pick_op(mix), pick_value(), pick_position());
    end
  endtask

  initial begin
    op_mix_t schedule [PHASES];
    schedule = '{MIX_GROW, MIX_LOOKUP, MIX_SHRINK, MIX_EVEN, MIX_GROW,
                 MIX_LOOKUP, MIX_EVEN, MIX_SHRINK, MIX_GROW};
    rst              = 1'b1;
    quiet            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_APPEND;
    req_ch.value     = '0;
    req_ch.position  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: operations on an empty list.
    send_item(OP_READ,   32'h0000_0000, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd63);
    send_item(OP_REMOVE, 32'h0000_0000, 6'd0);
    send_item(OP_CLEAR,  32'h0000_0000, 6'd0);
    // Directed: extreme values, duplicates, reads in and out of range.
    send_item(OP_APPEND, 32'h0000_0000, 6'd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_APPEND, 32'hA5A5_A5A5, 6'd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_APPEND, 32'h5A5A_5A5A, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd4);
    send_item(OP_READ,   32'h0000_0000, 6'd5);
    send_item(OP_READ,   32'h0000_0000, 6'd63);
    // Directed: remove with no match, then a remove that compacts two copies.
    send_item(OP_REMOVE, 32'h1234_5678, 6'd0);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd1);
    send_item(OP_READ,   32'h0000_0000, 6'd2);
    send_item(OP_REMOVE, 32'h0000_0000, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd0);
    // Directed: clear a filled list, then remove the only entry.
    send_item(OP_CLEAR,  32'h0000_0000, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd0);
    send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_item(OP_READ,   32'h0000_0000, 6'd0);

    // Random phases; the last one runs without idling on either side.
    for (int i = 0; i < PHASES; i++) begin
      if (i == PHASES - 1) begin
        quiet = 1'b1;
      end
      run_phase(schedule[i]);
    end
    req_ch.valid <= 1'b0;

    // Drain the remaining responses, then allow for the longest remove.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("Sent %0d appends, %0d removes, %0d reads and %0d clears;",
             sent_by_op[int'(OP_APPEND)], sent_by_op[int'(OP_REMOVE)],
             sent_by_op[int'(OP_READ)], sent_by_op[int'(OP_CLEAR)]);
    $display("checked %0d responses, with %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
